### hw/rtl/keypad_code_door_lock_assert.svh
// ----------------------------------------------------------------------------
// keypad_code_door_lock_assert.svh
// Assertion macros used by the door lock checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_DOOR_LOCK_ASSERT_SVH
`define KEYPAD_CODE_DOOR_LOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCDL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("door lock assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCDL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("door lock assertion failed");

`endif

### hw/rtl/kcdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcdl_pkg
// Types, codes and reset values shared by the door lock modules.
// ----------------------------------------------------------------------------
package kcdl_pkg;

    // Door modes, as reported on the status output
    typedef enum logic [2:0] {
        MODE_CLOSED   = 3'd0,
        MODE_ENTERING = 3'd1,
        MODE_ERROR    = 3'd2,
        MODE_UNLOCKED = 3'd3,
        MODE_OPEN     = 3'd4
    } t_mode;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_CODE_FIRST   = 3'd0,
        REG_CODE_SECOND  = 3'd1,
        REG_CODE_THIRD   = 3'd2,
        REG_WINDOW_START = 3'd3,
        REG_WINDOW_END   = 3'd4,
        REG_HOLD_TICKS   = 3'd5
    } t_reg_idx;

    localparam logic [3:0]  KEY_A_INDEX        = 4'd3;
    localparam logic [3:0]  RST_CODE_FIRST     = 4'd0;
    localparam logic [3:0]  RST_CODE_SECOND    = 4'd4;
    localparam logic [3:0]  RST_CODE_THIRD     = 4'd8;
    localparam logic [4:0]  RST_WINDOW_START   = 5'd8;
    localparam logic [4:0]  RST_WINDOW_END     = 5'd16;
    localparam logic [15:0] RST_HOLD_TICKS     = 16'd1000;
    localparam logic [1:0]  LAST_DIGIT_IDX     = 2'd2;

    // Lamp bit positions
    localparam int LAMP_UNLOCKED_BIT = 0;
    localparam int LAMP_LOCKED_BIT   = 1;
    localparam int LAMP_WRONG_BIT    = 2;
    localparam logic [2:0] LAMP_RESET = 3'b010;
    localparam logic [2:0] LAMP_OPEN_UNLOCKED = 3'b001;

    // Configuration as seen by the lock logic
    typedef struct packed {
        logic [3:0]  code_first;
        logic [3:0]  code_second;
        logic [3:0]  code_third;
        logic [4:0]  window_start;
        logic [4:0]  window_end;
        logic [15:0] hold_ticks;
    } t_cfg;

    // One tick's sample
    typedef struct packed {
        logic       key_pressed;
        logic [3:0] key_position;
        logic       handle_active;
        logic [4:0] clock_hour;
    } t_sample;

    // One result beat
    typedef struct packed {
        t_mode      door_status;
        logic [2:0] lamps;
    } t_result;

endpackage

### hw/rtl/kcdl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcdl_cfg_regs
// APB-style register file holding the code keys, hour window and hold time.
// ----------------------------------------------------------------------------
module kcdl_cfg_regs
    import kcdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_first   <= RST_CODE_FIRST;
            r_cfg.code_second  <= RST_CODE_SECOND;
            r_cfg.code_third   <= RST_CODE_THIRD;
            r_cfg.window_start <= RST_WINDOW_START;
            r_cfg.window_end   <= RST_WINDOW_END;
            r_cfg.hold_ticks   <= RST_HOLD_TICKS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CODE_FIRST:   r_cfg.code_first   <= pwdata[3:0];
                REG_CODE_SECOND:  r_cfg.code_second  <= pwdata[3:0];
                REG_CODE_THIRD:   r_cfg.code_third   <= pwdata[3:0];
                REG_WINDOW_START: r_cfg.window_start <= pwdata[4:0];
                REG_WINDOW_END:   r_cfg.window_end   <= pwdata[4:0];
                REG_HOLD_TICKS:   r_cfg.hold_ticks   <= pwdata[15:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_CODE_FIRST:   prdata = {28'd0, r_cfg.code_first};
            REG_CODE_SECOND:  prdata = {28'd0, r_cfg.code_second};
            REG_CODE_THIRD:   prdata = {28'd0, r_cfg.code_third};
            REG_WINDOW_START: prdata = {27'd0, r_cfg.window_start};
            REG_WINDOW_END:   prdata = {27'd0, r_cfg.window_end};
            REG_HOLD_TICKS:   prdata = {16'd0, r_cfg.hold_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/kcdl_lock_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcdl_lock_fsm
// Door mode state machine: code entry, error hold, unlock and open tracking.
// ----------------------------------------------------------------------------
module kcdl_lock_fsm
    import kcdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_mode       r_mode,     n_mode;
    logic [1:0]  r_digits,   n_digits;
    logic [3:0]  r_last_key, n_last_key;
    logic        r_mismatch, n_mismatch;
    logic [15:0] r_hold,     n_hold;
    logic [2:0]  r_lamp,     n_lamp;

    logic [3:0]  w_expected;
    logic        w_in_window;
    logic        w_new_digit;
    logic        w_miss;

    // expected code key for the current digit
    always_comb begin
        case (r_digits)
            2'd0:    w_expected = i_cfg.code_first;
            2'd1:    w_expected = i_cfg.code_second;
            default: w_expected = i_cfg.code_third;
        endcase
    end

    assign w_in_window = (i_sample.clock_hour >= i_cfg.window_start) &&
                         (i_sample.clock_hour <= i_cfg.window_end);
    assign w_new_digit = i_sample.key_pressed && (i_sample.key_position != r_last_key);
    assign w_miss      = r_mismatch || (i_sample.key_position != w_expected);

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_digits   = r_digits;
        n_last_key = r_last_key;
        n_mismatch = r_mismatch;
        n_hold     = r_hold;
        n_lamp     = r_lamp;
        unique case (r_mode)
            MODE_CLOSED: begin
                if (i_sample.key_pressed && i_sample.key_position == KEY_A_INDEX &&
                    w_in_window) begin
                    n_mode     = MODE_ENTERING;
                    n_digits   = 2'd0;
                    n_last_key = KEY_A_INDEX;
                    n_mismatch = 1'b0;
                end
            end
            MODE_ENTERING: begin
                if (w_new_digit) begin
                    n_last_key = i_sample.key_position;
                    n_mismatch = w_miss;
                    n_digits   = r_digits + 2'd1;
                    if (r_digits == LAST_DIGIT_IDX) begin
                        n_digits = 2'd0;
                        if (w_miss) begin
                            n_mode = MODE_ERROR;
                            n_hold = i_cfg.hold_ticks;
                            n_lamp[LAMP_WRONG_BIT] = 1'b1;
                        end else begin
                            n_mode = MODE_UNLOCKED;
                            n_lamp = LAMP_OPEN_UNLOCKED;
                        end
                    end
                end
            end
            MODE_ERROR: begin
                if (r_hold <= 16'd1) begin
                    n_hold = 16'd0;
                    n_mode = MODE_CLOSED;
                    n_lamp[LAMP_WRONG_BIT] = 1'b0;
                end else begin
                    n_hold = r_hold - 16'd1;
                end
            end
            MODE_UNLOCKED: begin
                if (i_sample.handle_active) begin
                    n_lamp[LAMP_UNLOCKED_BIT] = 1'b0;
                    n_mode = MODE_OPEN;
                end
            end
            MODE_OPEN: begin
                if (!i_sample.handle_active) begin
                    n_lamp[LAMP_LOCKED_BIT] = 1'b1;
                    n_mode = MODE_CLOSED;
                end
            end
            default: begin
                n_mode = MODE_CLOSED;
                n_lamp = LAMP_RESET;
            end
        endcase
    end

    // result beat: state as it stands after this tick
    always_comb begin
        o_result.door_status = n_mode;
        o_result.lamps       = n_lamp;
    end

    // state registers, updated once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CLOSED;
            r_digits   <= 2'd0;
            r_last_key <= KEY_A_INDEX;
            r_mismatch <= 1'b0;
            r_hold     <= 16'd0;
            r_lamp     <= LAMP_RESET;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_digits   <= n_digits;
            r_last_key <= n_last_key;
            r_mismatch <= n_mismatch;
            r_hold     <= n_hold;
            r_lamp     <= n_lamp;
        end
    end

endmodule

### hw/rtl/keypad_code_door_lock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_door_lock
// Keypad code door lock controller, one sample per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick's sample per beat:
//   key pressed flag and index, handle level and current hour.
//   Output channel (o_out_valid / i_out_ready) returns one result beat per
//   sample: door status and the three lamp drives after that tick.
//   Each sample passes through the input register, then the result register.
//   Throughput: one sample per cycle while the receiver keeps up; the state
//   machine update runs in the single logic stage between the input register
//   and the result register. When the receiver stalls, the result register
//   holds its beat and one more sample waits in the input register; the input
//   side stalls only when both are full.
//   Reset (i_rst_n low, synchronous) empties both registers, sets the door to
//   closed with the locked lamp on, and loads the default code keys 0,4,8,
//   the 8..16 hour window and a 1000-tick error hold.
//   Registers sit on the APB-style port at byte addresses 4*index; write them
//   only while no sample is in flight.
// ----------------------------------------------------------------------------
module keypad_code_door_lock
    import kcdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_key_pressed,
    input  logic [3:0]  i_key_position,
    input  logic        i_handle_active,
    input  logic [4:0]  i_clock_hour,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_door_status,
    output logic        o_unlocked_lamp,
    output logic        o_locked_lamp,
    output logic        o_wrong_code_lamp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    w_cfg;
    t_sample r_sample;
    t_result r_result;
    t_result w_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_step;
    logic    w_accept;

    kcdl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kcdl_lock_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_sample (r_sample),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // pipeline flow control
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample.key_pressed   <= i_key_pressed;
            r_sample.key_position  <= i_key_position;
            r_sample.handle_active <= i_handle_active;
            r_sample.clock_hour    <= i_clock_hour;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_door_status     = r_result.door_status;
    assign o_unlocked_lamp   = r_result.lamps[LAMP_UNLOCKED_BIT];
    assign o_locked_lamp     = r_result.lamps[LAMP_LOCKED_BIT];
    assign o_wrong_code_lamp = r_result.lamps[LAMP_WRONG_BIT];

endmodule

### hw/rtl/kcdl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcdl_checker
// Port-level assertions for the door lock, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_code_door_lock_assert.svh"

module kcdl_checker
    import kcdl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_door_status,
    input logic        o_unlocked_lamp,
    input logic        o_locked_lamp,
    input logic        o_wrong_code_lamp
);

    logic w_stalled;
    logic w_in_error;
    logic w_unlocked;

    assign w_stalled  = o_out_valid && !i_out_ready;
    assign w_in_error = (o_door_status == MODE_ERROR);
    assign w_unlocked = (o_door_status == MODE_UNLOCKED);

    // a stalled result beat stays valid and keeps its door status
    `KCDL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stalled, o_out_valid)
    `KCDL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, w_stalled, $stable(o_door_status))

    // wrong-code lamp is lit exactly in the error mode
    `KCDL_ASSERT_IMP(a_wrong_lamp, i_clk, i_rst_n, o_out_valid, o_wrong_code_lamp == w_in_error)

    // unlocked door: unlocked lamp on, locked lamp off
    `KCDL_ASSERT_IMP(a_unlock_lamps, i_clk, i_rst_n, o_out_valid && w_unlocked, o_unlocked_lamp && !o_locked_lamp)

endmodule

bind keypad_code_door_lock kcdl_checker u_kcdl_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code door lock.
// ----------------------------------------------------------------------------
// Tick samples go in over the valid/ready input channel. Every result beat is
// compared field by field with an in-bench model of the lock that keeps its
// own copy of the registers and the door state. A short directed opening
// covers the hour window edges, held keys, key A as a digit, the handle
// sequence, an empty window, zero and long error holds, a maximum hold
// readback and writes to unmapped addresses. Four random phases follow,
// mostly well-formed entry attempts with noise between them, each under a
// different idle/stall mix and with freshly programmed registers.
// ----------------------------------------------------------------------------
module tb_top;
    import kcdl_pkg::*;

    localparam int         CLK_HALF_NS      = 5;
    localparam int         RESET_CYCLES     = 10;
    localparam int         PHASE_SAMPLES    = 350;
    localparam int         CYCLE_LIMIT      = 2_000_000;
    localparam int         DRAIN_CYCLES     = 4;
    localparam logic [4:0] HOUR_MAX         = 5'd31;
    localparam logic [4:0] HOUR_LAST        = 5'd23;
    localparam logic [4:0] ADDR_UNMAPPED_LO = 5'd24;
    localparam logic [4:0] ADDR_UNMAPPED_HI = 5'd28;
    localparam logic [3:0] KEY_D_INDEX      = 4'd15;
    localparam int         ENTRY_KEYS       = 3;

    // ------------------------------------------------------------------------
    // Lock model and result store
    // ------------------------------------------------------------------------
    class lock_scoreboard;
        localparam int MAX_PRINTED = 50;

        t_cfg        cfg;
        t_mode       mode;
        logic [1:0]  digits;
        logic [3:0]  last_key;
        bit          wrong_digit;
        logic [15:0] hold;
        logic [2:0]  lamps;
        t_result     status_expected[$];

        int samples_seen = 0;
        int samples_live = 0;
        int results_seen = 0;
        int unlocks      = 0;
        int wrong_codes  = 0;
        int failures     = 0;

        function new();
            cfg = '{code_first: RST_CODE_FIRST, code_second: RST_CODE_SECOND,
                    code_third: RST_CODE_THIRD, window_start: RST_WINDOW_START,
                    window_end: RST_WINDOW_END, hold_ticks: RST_HOLD_TICKS};
            mode        = MODE_CLOSED;
            digits      = '0;
            last_key    = KEY_A_INDEX;
            wrong_digit = 1'b0;
            hold        = '0;
            lamps       = LAMP_RESET;
        endfunction

        task report_mismatch(string msg);
            failures++;
            if (failures <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // register write as the block decodes it; unmapped addresses drop
        function void write_register(logic [4:0] addr, logic [31:0] data);
            case (addr[4:2])
                REG_CODE_FIRST:   cfg.code_first   = data[3:0];
                REG_CODE_SECOND:  cfg.code_second  = data[3:0];
                REG_CODE_THIRD:   cfg.code_third   = data[3:0];
                REG_WINDOW_START: cfg.window_start = data[4:0];
                REG_WINDOW_END:   cfg.window_end   = data[4:0];
                REG_HOLD_TICKS:   cfg.hold_ticks   = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(t_reg_idx idx);
            case (idx)
                REG_CODE_FIRST:   return 32'(cfg.code_first);
                REG_CODE_SECOND:  return 32'(cfg.code_second);
                REG_CODE_THIRD:   return 32'(cfg.code_third);
                REG_WINDOW_START: return 32'(cfg.window_start);
                REG_WINDOW_END:   return 32'(cfg.window_end);
                REG_HOLD_TICKS:   return 32'(cfg.hold_ticks);
                default:          return '0;
            endcase
        endfunction

        // advance the lock by one accepted tick and queue its status beat
        function void note_sample(t_sample s);
            logic [3:0] wanted;
            t_result    r;
            samples_seen++;
            if (mode != MODE_ERROR)
                samples_live++;
            case (mode)
                MODE_CLOSED: begin
                    if (s.key_pressed && s.key_position == KEY_A_INDEX &&
                        s.clock_hour >= cfg.window_start &&
                        s.clock_hour <= cfg.window_end) begin
                        mode        = MODE_ENTERING;
                        digits      = '0;
                        last_key    = KEY_A_INDEX;
                        wrong_digit = 1'b0;
                    end
                end
                MODE_ENTERING: begin
                    if (s.key_pressed && s.key_position != last_key) begin
                        last_key = s.key_position;
                        case (digits)
                            2'd0:    wanted = cfg.code_first;
                            2'd1:    wanted = cfg.code_second;
                            default: wanted = cfg.code_third;
                        endcase
                        if (s.key_position != wanted)
                            wrong_digit = 1'b1;
                        if (digits == LAST_DIGIT_IDX) begin
                            digits = '0;
                            if (wrong_digit) begin
                                mode = MODE_ERROR;
                                hold = cfg.hold_ticks;
                                lamps[LAMP_WRONG_BIT] = 1'b1;
                                wrong_codes++;
                            end else begin
                                mode  = MODE_UNLOCKED;
                                lamps = LAMP_OPEN_UNLOCKED;
                                unlocks++;
                            end
                        end else begin
                            digits = digits + 2'd1;
                        end
                    end
                end
                MODE_ERROR: begin
                    // a zero hold behaves like a hold of one
                    if (hold <= 16'd1) begin
                        hold = '0;
                        mode = MODE_CLOSED;
                        lamps[LAMP_WRONG_BIT] = 1'b0;
                    end else begin
                        hold = hold - 16'd1;
                    end
                end
                MODE_UNLOCKED: begin
                    if (s.handle_active) begin
                        lamps[LAMP_UNLOCKED_BIT] = 1'b0;
                        mode = MODE_OPEN;
                    end
                end
                MODE_OPEN: begin
                    if (!s.handle_active) begin
                        lamps[LAMP_LOCKED_BIT] = 1'b1;
                        mode = MODE_CLOSED;
                    end
                end
                default: begin
                    mode  = MODE_CLOSED;
                    lamps = LAMP_RESET;
                end
            endcase
            r.door_status = mode;
            r.lamps       = lamps;
            status_expected.push_back(r);
        endfunction

        // compare one result beat with the oldest queued status
        task check_outcome(logic [2:0] status, logic unl, logic lck, logic wrg);
            t_result want;
            if (status_expected.size() == 0) begin
                report_mismatch($sformatf("result beat with no sample outstanding, status %0d",
                                          status));
                return;
            end
            want = status_expected.pop_front();
            results_seen++;
            if (status !== want.door_status)
                report_mismatch($sformatf("beat %0d door_status got %0d, expected %0d",
                                          results_seen, status, want.door_status));
            if (unl !== want.lamps[LAMP_UNLOCKED_BIT])
                report_mismatch($sformatf("beat %0d unlocked_lamp got %0b, expected %0b",
                                          results_seen, unl, want.lamps[LAMP_UNLOCKED_BIT]));
            if (lck !== want.lamps[LAMP_LOCKED_BIT])
                report_mismatch($sformatf("beat %0d locked_lamp got %0b, expected %0b",
                                          results_seen, lck, want.lamps[LAMP_LOCKED_BIT]));
            if (wrg !== want.lamps[LAMP_WRONG_BIT])
                report_mismatch($sformatf("beat %0d wrong_code_lamp got %0b, expected %0b",
                                          results_seen, wrg, want.lamps[LAMP_WRONG_BIT]));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_key_pressed;
    logic [3:0]  i_key_position;
    logic        i_handle_active;
    logic [4:0]  i_clock_hour;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_door_status;
    logic        o_unlocked_lamp;
    logic        o_locked_lamp;
    logic        o_wrong_code_lamp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lock_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    keypad_code_door_lock dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_key_pressed     (i_key_pressed),
        .i_key_position    (i_key_position),
        .i_handle_active   (i_handle_active),
        .i_clock_hour      (i_clock_hour),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_door_status     (o_door_status),
        .o_unlocked_lamp   (o_unlocked_lamp),
        .o_locked_lamp     (o_locked_lamp),
        .o_wrong_code_lamp (o_wrong_code_lamp),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 10 ns clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog: no completion within %0d cycles", CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next cycle's ready
    initial i_out_ready <= 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_outcome(o_door_status, o_unlocked_lamp, o_locked_lamp,
                             o_wrong_code_lamp);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        sb.write_register(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [4:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        apb_write({idx, 2'b00}, data);
    endtask

    // read every register back against the model copy
    task automatic verify_registers();
        int          r;
        logic [31:0] got;
        for (r = REG_CODE_FIRST; r <= REG_HOLD_TICKS; r++) begin
            apb_read({t_reg_idx'(r), 2'b00}, got);
            if (got !== sb.register_value(t_reg_idx'(r)))
                sb.report_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                             r, got, sb.register_value(t_reg_idx'(r))));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample channel
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic pressed, input logic [3:0] key,
                               input logic handle, input logic [4:0] hour);
        t_sample s;
        s = '{key_pressed: pressed, key_position: key, handle_active: handle,
              clock_hour: hour};
        // random idle gap before the beat
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_key_pressed   <= pressed;
        i_key_position  <= key;
        i_handle_active <= handle;
        i_clock_hour    <= hour;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_sample(s);
    endtask

    task automatic noise_tick();
        send_sample(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                    5'($urandom_range(HOUR_MAX)));
    endtask

    task automatic quiet_tick(input logic handle);
        send_sample(1'b0, 4'($urandom_range(15)), handle, 5'($urandom_range(HOUR_MAX)));
    endtask

    task automatic press_key(input logic [3:0] key);
        send_sample(1'b1, key, 1'($urandom_range(1)), 5'($urandom_range(HOUR_MAX)));
    endtask

    // let the channel go idle and every expected beat come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.status_expected.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic drain_error_hold();
        while (sb.mode == MODE_ERROR)
            noise_tick();
    endtask

    function automatic logic [4:0] window_hour();
        if (sb.cfg.window_start <= sb.cfg.window_end && $urandom_range(7) != 0)
            return 5'($urandom_range(sb.cfg.window_end, sb.cfg.window_start));
        return 5'($urandom_range(HOUR_MAX));
    endfunction

    function automatic logic [3:0] distinct_key(input logic [3:0] prev);
        logic [3:0] k;
        do begin
            k = 4'($urandom_range(15));
        end while (k == prev);
        return k;
    endfunction

    // one entry attempt: A, three digits (one wrong at times), handle cycle
    task automatic entry_attempt();
        logic [3:0] digit_keys [ENTRY_KEYS];
        logic [3:0] key;
        int         bad_pos;
        int         d;
        bad_pos       = ($urandom_range(3) == 0) ? $urandom_range(ENTRY_KEYS - 1) : -1;
        digit_keys[0] = sb.cfg.code_first;
        digit_keys[1] = sb.cfg.code_second;
        digit_keys[2] = sb.cfg.code_third;
        send_sample(1'b1, KEY_A_INDEX, 1'($urandom_range(1)), window_hour());
        repeat ($urandom_range(2)) press_key(KEY_A_INDEX);
        for (d = 0; d < ENTRY_KEYS; d++) begin
            key = digit_keys[d];
            if (d == bad_pos)
                key = key ^ 4'($urandom_range(15, 1));
            repeat ($urandom_range(2)) quiet_tick(1'($urandom_range(1)));
            repeat ($urandom_range(2, 1)) press_key(key);
        end
        repeat ($urandom_range(3)) quiet_tick(1'b0);
        repeat ($urandom_range(3, 1)) quiet_tick(1'b1);
        repeat ($urandom_range(2, 1)) quiet_tick(1'b0);
    endtask

    // fresh code, window and hold for one random phase
    task automatic program_random_setup();
        logic [3:0] k1;
        logic [3:0] k2;
        logic [3:0] k3;
        logic [4:0] ws;
        logic [4:0] we;
        k1 = distinct_key(KEY_A_INDEX);
        k2 = distinct_key(k1);
        k3 = distinct_key(k2);
        ws = ($urandom_range(2) == 0) ? 5'd0 : 5'($urandom_range(HOUR_LAST));
        we = ($urandom_range(2) == 0) ? HOUR_LAST : 5'($urandom_range(HOUR_LAST, ws));
        write_reg(REG_CODE_FIRST, 32'(k1));
        write_reg(REG_CODE_SECOND, 32'(k2));
        write_reg(REG_CODE_THIRD, 32'(k3));
        write_reg(REG_WINDOW_START, 32'(ws));
        write_reg(REG_WINDOW_END, 32'(we));
        write_reg(REG_HOLD_TICKS, ($urandom_range(3) == 0) ? $urandom_range(1)
                                                             : $urandom_range(40, 2));
        verify_registers();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        int base;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_key_pressed   <= 1'b0;
        i_key_position  <= '0;
        i_handle_active <= 1'b0;
        i_clock_hour    <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        verify_registers();

        // default code 0,4,8 and window 8..16
        send_sample(1'b0, KEY_A_INDEX, 1'b0, RST_WINDOW_START);      // no key down
        send_sample(1'b1, KEY_A_INDEX, 1'b0, RST_WINDOW_START - 5'd1);
        send_sample(1'b1, KEY_A_INDEX, 1'b0, HOUR_MAX);              // hour above 23
        send_sample(1'b1, KEY_A_INDEX, 1'b0, RST_WINDOW_START);      // start inclusive
        send_sample(1'b1, KEY_A_INDEX, 1'b1, RST_WINDOW_START);      // held A, no digit
        send_sample(1'b1, RST_CODE_FIRST, 1'b1, 5'd3);               // handle ignored
        send_sample(1'b0, RST_CODE_SECOND, 1'b0, 5'd3);
        send_sample(1'b1, RST_CODE_SECOND, 1'b0, 5'd3);
        send_sample(1'b1, RST_CODE_THIRD, 1'b0, 5'd3);               // unlocks
        send_sample(1'b1, KEY_A_INDEX, 1'b1, RST_WINDOW_START);      // opens
        send_sample(1'b0, 4'd0, 1'b0, 5'd0);                         // closes, relocks

        // short hold keeps the error drain brief
        settle();
        write_reg(REG_HOLD_TICKS, 32'd25);
        send_sample(1'b1, KEY_A_INDEX, 1'b0, RST_WINDOW_END);        // end inclusive
        send_sample(1'b1, KEY_D_INDEX, 1'b0, 5'd0);
        send_sample(1'b1, KEY_A_INDEX, 1'b0, 5'd0);                  // A taken as digit
        send_sample(1'b1, KEY_D_INDEX, 1'b0, 5'd0);                  // wrong code
        drain_error_hold();

        // extreme code keys, empty window, zero hold
        settle();
        write_reg(REG_CODE_FIRST, 32'(KEY_D_INDEX));
        write_reg(REG_CODE_SECOND, 32'd0);
        write_reg(REG_CODE_THIRD, 32'(KEY_D_INDEX));
        write_reg(REG_WINDOW_START, 32'd20);
        write_reg(REG_WINDOW_END, 32'd5);
        write_reg(REG_HOLD_TICKS, 32'd0);
        verify_registers();
        send_sample(1'b1, KEY_A_INDEX, 1'b0, 5'd20);
        settle();
        write_reg(REG_WINDOW_END, 32'(HOUR_MAX));
        send_sample(1'b1, KEY_A_INDEX, 1'b0, HOUR_MAX);
        send_sample(1'b1, KEY_D_INDEX, 1'b0, 5'd0);
        send_sample(1'b1, 4'd0, 1'b0, 5'd0);
        send_sample(1'b1, 4'd14, 1'b0, 5'd0);                        // error, lamp one tick
        quiet_tick(1'b0);

        // maximum hold read back, then a long hold rewritten while the error runs
        settle();
        write_reg(REG_WINDOW_START, 32'd0);
        write_reg(REG_WINDOW_END, 32'(HOUR_LAST));
        write_reg(REG_HOLD_TICKS, 32'hFFFF);
        verify_registers();
        write_reg(REG_HOLD_TICKS, 32'd200);
        send_sample(1'b1, KEY_A_INDEX, 1'b0, 5'd0);
        send_sample(1'b1, 4'd0, 1'b0, 5'd0);
        send_sample(1'b1, 4'd1, 1'b0, 5'd0);
        send_sample(1'b1, 4'd2, 1'b0, 5'd0);
        settle();
        write_reg(REG_HOLD_TICKS, 32'd1);
        apb_write(ADDR_UNMAPPED_LO, '1);
        apb_write(ADDR_UNMAPPED_HI, '1);
        verify_registers();
        drain_error_hold();

        // random phases under different idle/stall mixes
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            program_random_setup();
            base = sb.samples_seen;
            while (sb.samples_seen - base < PHASE_SAMPLES) begin
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(8, 1)) noise_tick();
                else
                    entry_attempt();
            end
        end

        settle();
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Compared %0d result beats for %0d samples (%0d outside an error hold).",
                 sb.results_seen, sb.samples_seen, sb.samples_live);
        $display("Saw %0d unlocks and %0d wrong codes over directed and four random phases.",
                 sb.unlocks, sb.wrong_codes);
        if (sb.failures == 0 && sb.status_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
